### hdl/compass_heading_magnitude_unit_macros.svh
// Assertion helpers for the compass heading block.
// The short forms assume a clock named clk_i and an active-low reset named rst_ni.
`ifndef COMPASS_HEADING_MAGNITUDE_UNIT_MACROS_SVH
`define COMPASS_HEADING_MAGNITUDE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

`define CHM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("chm assertion failed");

`define CHM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("chm assertion failed");

`else

`define CHM_ASSERT(lbl, prop)

`define CHM_ASSERT_IMPL(lbl, ante, cons)

`endif

`endif

### hdl/chm_pkg.sv
package chm_pkg;

  localparam int AXIS_W    = 16;  // raw axis sample
  localparam int DECL_W    = 15;  // declination register
  localparam int HEAD_W    = 15;  // wrapped heading
  localparam int ANG_W     = 15;  // signed angle, 1/64 degree, clamped to a half turn
  localparam int MAG_W     = 16;  // field magnitude
  localparam int SUM_W     = 32;  // sum of three squares
  localparam int CORD_W    = 20;  // CORDIC x/y datapath, covers the gain growth
  localparam int ACC_W     = 24;  // angle accumulator, 1/16384 degree
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;

  localparam int DEG180_FINE = 2949120;
  localparam int FULL_TURN   = 23040;
  localparam int HALF_TURN   = 11520;
  localparam int ROUND_HALF  = 128;
  localparam int FINE_SHIFT  = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SOLVE
  } chm_state_e;

  // round(atan(2^-i) * 16384 * 180 / pi)
  function automatic logic signed [ACC_W-1:0] atan_fine(input logic [TAB_IDX_W-1:0] idx);
    logic signed [ACC_W-1:0] v;
    unique case (idx)
      5'd0:    v = 24'sd737280;
      5'd1:    v = 24'sd435242;
      5'd2:    v = 24'sd229970;
      5'd3:    v = 24'sd116736;
      5'd4:    v = 24'sd58595;
      5'd5:    v = 24'sd29326;
      5'd6:    v = 24'sd14667;
      5'd7:    v = 24'sd7334;
      5'd8:    v = 24'sd3667;
      5'd9:    v = 24'sd1833;
      5'd10:   v = 24'sd917;
      5'd11:   v = 24'sd458;
      5'd12:   v = 24'sd229;
      5'd13:   v = 24'sd115;
      5'd14:   v = 24'sd57;
      5'd15:   v = 24'sd29;
      5'd16:   v = 24'sd14;
      5'd17:   v = 24'sd7;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      5'd20:   v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/chm_stream_if.sv
interface chm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                data_ready;
  logic signed [chm_pkg::AXIS_W-1:0]   x_field;
  logic signed [chm_pkg::AXIS_W-1:0]   y_field;
  logic signed [chm_pkg::AXIS_W-1:0]   z_field;

  modport source (output valid, data_ready, x_field, y_field, z_field, input ready);
  modport sink   (input valid, data_ready, x_field, y_field, z_field, output ready);
endinterface

interface chm_out_if;
  logic                         valid;
  logic                         ready;
  logic [chm_pkg::HEAD_W-1:0]   heading;
  logic [chm_pkg::MAG_W-1:0]    magnitude;
  logic                         sample_fresh;

  modport source (output valid, heading, magnitude, sample_fresh, input ready);
  modport sink   (input valid, heading, magnitude, sample_fresh, output ready);
endinterface

### hdl/compass_heading_magnitude_unit.sv
// A result is valid once both the CORDIC and the square root, which runs after the squaring
//   pass, have finished and the output slot is free.
// A new request is not taken until the last result has been loaded; ready is high only while idle.
// A finished result waits in the output register and holds until taken.
// Reset (async, active low): held sample clears to zero, declination returns to -538.
`include "compass_heading_magnitude_unit_macros.svh"

module compass_heading_magnitude_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  chm_in_if.sink                               in_i,
  chm_out_if.source                            out_o,
  input  logic                                 cfg_we_i,
  input  logic signed [chm_pkg::DECL_W-1:0]    cfg_data_i
);

  localparam logic [2:0] SQ_LAST = 3'd4;  // squares at 0..2, accumulate at 1..3, sum ready at 4
  localparam logic signed [chm_pkg::DECL_W-1:0] DECL_LIM = chm_pkg::DECL_W'(chm_pkg::HALF_TURN);
  localparam logic signed [chm_pkg::DECL_W-1:0] DECL_RST = -chm_pkg::DECL_W'(538);
  localparam logic signed [chm_pkg::ANG_W:0] TURN = (chm_pkg::ANG_W + 1)'(chm_pkg::FULL_TURN);

  chm_pkg::chm_state_e state_q, state_d;

  // Control strobes from the sequencer
  logic in_ready, cordic_start, sqrt_start, sq_acc, load_out, slot_free;

  // Held sample and configuration
  logic signed [chm_pkg::AXIS_W-1:0]  held_x_q, held_y_q, held_z_q;
  logic signed [chm_pkg::DECL_W-1:0]  decl_q, decl_d;
  logic                               fresh_q;

  // Squaring pass: one shared multiplier, product registered before the add
  logic [2:0]                          sq_cnt_q;
  logic signed [chm_pkg::AXIS_W-1:0]   sq_op;
  logic signed [chm_pkg::SUM_W-1:0]    sq_prod;
  logic [chm_pkg::SUM_W-1:0]           prod_q, sum_q, sum_d;

  // Iterative units
  logic                               cordic_done, sqrt_done;
  logic signed [chm_pkg::ANG_W-1:0]   angle;
  logic [chm_pkg::MAG_W-1:0]          root;

  // Heading wrap and output register
  logic signed [chm_pkg::ANG_W:0]     h_sum, h_wrap;
  logic                               out_valid_q;
  logic [chm_pkg::HEAD_W-1:0]         heading_q;
  logic [chm_pkg::MAG_W-1:0]          magnitude_q;
  logic                               out_fresh_q;

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE takes a request, SQUARE runs the multiplier over x, y, z
  // (the CORDIC starts on its first cycle, the square root on its last), SOLVE waits for both units and
  // for a free output slot.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chm_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = chm_pkg::ST_SQUARE;
      end
      chm_pkg::ST_SQUARE: begin
        if (sq_cnt_q == SQ_LAST) state_d = chm_pkg::ST_SOLVE;
      end
      chm_pkg::ST_SOLVE: begin
        if (load_out) state_d = chm_pkg::ST_IDLE;
      end
      default: state_d = chm_pkg::ST_IDLE;
    endcase
  end

  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    in_ready     = 1'b0;
    cordic_start = 1'b0;
    sqrt_start   = 1'b0;
    sq_acc       = 1'b0;
    load_out     = 1'b0;
    unique case (state_q)
      chm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      chm_pkg::ST_SQUARE: begin
        cordic_start = (sq_cnt_q == '0);
        sq_acc       = (sq_cnt_q != '0) && (sq_cnt_q != SQ_LAST);
        sqrt_start   = (sq_cnt_q == SQ_LAST);
      end
      chm_pkg::ST_SOLVE: begin
        load_out = cordic_done && sqrt_done && slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= chm_pkg::ST_IDLE;
      sq_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == chm_pkg::ST_SQUARE && sq_cnt_q != SQ_LAST) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end else begin
        sq_cnt_q <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Held sample: replace on a fresh request, otherwise keep. Declination is
  // saturated to a half turn on write, which matches saturating on every use.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (cfg_data_i > DECL_LIM) begin
      decl_d = DECL_LIM;
    end else if (cfg_data_i < -DECL_LIM) begin
      decl_d = -DECL_LIM;
    end else begin
      decl_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_y_q <= '0;
      held_z_q <= '0;
      decl_q   <= DECL_RST;
      fresh_q  <= 1'b0;
    end else begin
      if (cfg_we_i) decl_q <= decl_d;
      if (in_i.valid && in_ready) begin
        fresh_q <= in_i.data_ready;
        if (in_i.data_ready) begin
          held_x_q <= in_i.x_field;
          held_y_q <= in_i.y_field;
          held_z_q <= in_i.z_field;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sum of squares through the shared multiplier
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (sq_cnt_q)
      3'd0:    sq_op = held_x_q;
      3'd1:    sq_op = held_y_q;
      default: sq_op = held_z_q;
    endcase
    sq_prod = sq_op * sq_op;
    sum_d   = ((sq_cnt_q == 3'd1) ? '0 : sum_q) + prod_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == chm_pkg::ST_SQUARE) prod_q <= $unsigned(sq_prod);
    if (sq_acc) sum_q <= sum_d;
  end

  // ---------------------------------------------------------------------------
  // Iterative units
  // ---------------------------------------------------------------------------
  chm_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .x_i     (held_x_q),
    .y_i     (held_y_q),
    .done_o  (cordic_done),
    .angle_o (angle)
  );

  chm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sum_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // ---------------------------------------------------------------------------
  // Heading: add declination, wrap below zero and above a full turn
  // ---------------------------------------------------------------------------
  always_comb begin
    h_sum = (chm_pkg::ANG_W + 1)'(angle) + (chm_pkg::ANG_W + 1)'(decl_q);
    if (h_sum < 0) begin
      h_wrap = h_sum + TURN;
    end else if (h_sum > TURN) begin
      h_wrap = h_sum - TURN;
    end else begin
      h_wrap = h_sum;
    end
  end

  // Output register: load when the slot is free, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      heading_q   <= chm_pkg::HEAD_W'(h_wrap);
      magnitude_q <= root;
      out_fresh_q <= fresh_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.heading      = heading_q;
  assign out_o.magnitude    = magnitude_q;
  assign out_o.sample_fresh = out_fresh_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `CHM_ASSERT(a_accept_starts, (in_i.valid && in_ready) |=> (state_q == chm_pkg::ST_SQUARE))
  `CHM_ASSERT(a_sqrt_restarts, sqrt_start |=> !sqrt_done)
  `CHM_ASSERT_IMPL(a_heading_range, out_valid_q, heading_q <= chm_pkg::HEAD_W'(23040))
  `CHM_ASSERT_IMPL(a_mag_range, out_valid_q, magnitude_q <= chm_pkg::MAG_W'(56756))

endmodule

### hdl/chm_cordic.sv
module chm_cordic #(
  parameter int STEPS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [chm_pkg::AXIS_W-1:0]   x_i,
  input  logic signed [chm_pkg::AXIS_W-1:0]   y_i,
  output logic                                done_o,
  output logic signed [chm_pkg::ANG_W-1:0]    angle_o
);

  localparam int STEPS_EFF = (STEPS > chm_pkg::TAB_LEN) ? chm_pkg::TAB_LEN : STEPS;
  localparam logic [chm_pkg::TAB_IDX_W-1:0] LAST = chm_pkg::TAB_IDX_W'(STEPS_EFF - 1);
  localparam logic signed [chm_pkg::ACC_W-1:0] DEG180 = chm_pkg::ACC_W'(chm_pkg::DEG180_FINE);
  localparam logic signed [chm_pkg::ACC_W-1:0] CLAMP = chm_pkg::ACC_W'(chm_pkg::HALF_TURN);
  localparam logic signed [chm_pkg::ACC_W-1:0] RND = chm_pkg::ACC_W'(chm_pkg::ROUND_HALF);

  logic                                 busy_q, fin_q, done_q;
  logic [chm_pkg::TAB_IDX_W-1:0]        cnt_q;
  logic signed [chm_pkg::CORD_W-1:0]    x_q, y_q, x_d, y_d, xs, ys, x_ext, y_ext;
  logic signed [chm_pkg::ACC_W-1:0]     a_q, a_d, step, rnd, clamped;
  logic                                 zero_q;
  logic signed [chm_pkg::ANG_W-1:0]     angle_q;

  always_comb begin
    x_ext = chm_pkg::CORD_W'(x_i);
    y_ext = chm_pkg::CORD_W'(y_i);
    xs    = x_q >>> cnt_q;
    ys    = y_q >>> cnt_q;
    step  = chm_pkg::atan_fine(cnt_q);
    // Turn a left-half vector by 180 degrees before the rotations
    if (start_i) begin
      if (x_i < 0) begin
        x_d = -x_ext;
        y_d = -y_ext;
        a_d = (y_i >= 0) ? DEG180 : -DEG180;
      end else begin
        x_d = x_ext;
        y_d = y_ext;
        a_d = '0;
      end
    end else if (y_q > 0) begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      a_d = a_q + step;
    end else begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      a_d = a_q - step;
    end
    rnd = (a_q + RND) >>> chm_pkg::FINE_SHIFT;
    if (rnd > CLAMP) begin
      clamped = CLAMP;
    end else if (rnd < -CLAMP) begin
      clamped = -CLAMP;
    end else begin
      clamped = rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        fin_q  <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else if (fin_q) begin
      fin_q  <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i || busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      a_q <= a_d;
    end
    if (start_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
    end
    if (fin_q) begin
      angle_q <= zero_q ? '0 : chm_pkg::ANG_W'(clamped);
    end
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule

### hdl/chm_isqrt.sv
module chm_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [chm_pkg::SUM_W-1:0]    value_i,
  output logic                         done_o,
  output logic [chm_pkg::MAG_W-1:0]    root_o
);

  localparam int REM_W = chm_pkg::MAG_W + 1;
  localparam int CNT_W = $clog2(chm_pkg::MAG_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(chm_pkg::MAG_W - 1);

  logic                        busy_q, done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [chm_pkg::SUM_W-1:0]   val_q;
  logic [REM_W-1:0]            rem_q, rem_d;
  logic [chm_pkg::MAG_W-1:0]   root_q, root_d;
  logic [REM_W+1:0]            rem_sh, trial;

  // One result bit per cycle: bring down two bits, try 4r+1
  always_comb begin
    rem_sh = {rem_q, val_q[chm_pkg::SUM_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = REM_W'(rem_sh - trial);
      root_d = {root_q[chm_pkg::MAG_W-2:0], 1'b1};
    end else begin
      rem_d  = REM_W'(rem_sh);
      root_d = {root_q[chm_pkg::MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[chm_pkg::SUM_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
